### rtl/core/cubemap_to_equirect_address_defines.svh
// ----------------------------------------------------------------------------
// Cube-map to equirectangular addressing: assertion macros
// Concurrent check macros for the addressing block; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef CUBEMAP_TO_EQUIRECT_ADDRESS_DEFINES_SVH
`define CUBEMAP_TO_EQUIRECT_ADDRESS_DEFINES_SVH
`ifndef SYNTH
`define C2E_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2e check failed");
`define C2E_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2e check failed");
`else
`define C2E_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define C2E_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/c2e_pkg.sv
// ----------------------------------------------------------------------------
// Cube-map to equirectangular addressing: package
// Word types, cell state types, fixed-point constants and tables.
// ----------------------------------------------------------------------------
package c2e_pkg;

    localparam int LAT           = 65;
    localparam int UV_CELLS      = 17;
    localparam int SQRT_CELLS    = 19;
    localparam int CORDIC_CELLS  = 16;
    localparam int FI_DLY        = 17;
    localparam int D1_DLY        = 21;
    localparam int AZ_DLY        = 21;
    localparam int FO_DLY        = 59;

    localparam logic [12:0] MAX_FACE_RES   = 13'd4096;
    localparam logic [13:0] MAX_SRC_WIDTH  = 14'd8192;
    localparam logic [13:0] MAX_SRC_HEIGHT = 14'd8192;
    localparam logic [2:0]  MAX_CHANNELS   = 3'd4;
    localparam logic [2:0]  FACE_MAX       = 3'd5;

    localparam logic signed [18:0] ONE_Q   = 19'sd65536;
    localparam logic signed [20:0] PI_Q    = 21'sd205887;
    localparam logic signed [20:0] P_Q     = 21'sd205881;
    localparam logic signed [20:0] HP_Q    = 21'sd102941;
    localparam logic signed [20:0] SPAN_Q  = 21'sd411762;

    // floor(2^32 / divisor) for the angle scaling quotients
    localparam logic [13:0] SPAN_RCP = 14'd10430;
    localparam logic [14:0] P_RCP    = 15'd20861;

    localparam logic signed [1:0] CP = 2'sb01;
    localparam logic signed [1:0] CN = 2'sb11;
    localparam logic signed [1:0] CZ = 2'sb00;

    typedef enum logic [1:0] {
        CFG_FACE_RES   = 2'd0,
        CFG_SRC_WIDTH  = 2'd1,
        CFG_SRC_HEIGHT = 2'd2,
        CFG_CHANNELS   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [2:0]  face_index;
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
    } t_item;

    typedef struct packed {
        logic [12:0] sample_col;
        logic [12:0] sample_row;
        logic [27:0] sample_offset;
        logic [28:0] face_offset;
    } t_result;

    typedef struct packed {
        logic [19:0] r;
        logic [17:0] q;
        logic [12:0] n;
        logic        ovf;
    } t_div;

    typedef struct packed {
        logic [36:0] v;
        logic [37:0] acc;
    } t_sqrt;

    typedef struct packed {
        logic signed [21:0] x;
        logic signed [21:0] y;
        logic signed [20:0] ang;
    } t_cordic;

    typedef struct packed {
        logic signed [1:0] sx, sy, sz;
        logic signed [1:0] rx, ry, rz;
        logic signed [1:0] ux, uy, uz;
    } t_face_dir;

    function automatic t_face_dir face_dir(input logic [2:0] f);
        t_face_dir d;
        case (f)
            3'd0:    d = '{CP, CP, CN, CN, CZ, CZ, CZ, CN, CZ};
            3'd1:    d = '{CN, CP, CP, CP, CZ, CZ, CZ, CN, CZ};
            3'd2:    d = '{CN, CP, CP, CZ, CZ, CN, CP, CZ, CZ};
            3'd3:    d = '{CP, CN, CP, CZ, CZ, CN, CN, CZ, CZ};
            3'd4:    d = '{CP, CP, CP, CZ, CZ, CN, CZ, CN, CZ};
            default: d = '{CN, CP, CN, CZ, CZ, CP, CZ, CN, CZ};
        endcase
        return d;
    endfunction

    function automatic logic signed [20:0] atan_q(input logic [3:0] k);
        logic signed [20:0] a;
        case (k)
            4'd0:    a = 21'sd51472;
            4'd1:    a = 21'sd30386;
            4'd2:    a = 21'sd16055;
            4'd3:    a = 21'sd8150;
            4'd4:    a = 21'sd4091;
            4'd5:    a = 21'sd2047;
            4'd6:    a = 21'sd1024;
            4'd7:    a = 21'sd512;
            4'd8:    a = 21'sd256;
            4'd9:    a = 21'sd128;
            4'd10:   a = 21'sd64;
            4'd11:   a = 21'sd32;
            4'd12:   a = 21'sd16;
            4'd13:   a = 21'sd8;
            4'd14:   a = 21'sd4;
            default: a = 21'sd2;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/c2e_div_cell.sv
// ----------------------------------------------------------------------------
// Restoring divide cell
// Brings in one numerator bit, trial-subtracts the divisor, shifts in one
// quotient bit and hands the partial state on.
// ----------------------------------------------------------------------------
module c2e_div_cell (
    input  logic             i_clk,
    input  logic [19:0]      i_divisor,
    input  c2e_pkg::t_div    i_cell,
    output c2e_pkg::t_div    o_cell
);

    logic [19:0]   w_rr;
    logic          w_ge;
    c2e_pkg::t_div n_cell;
    c2e_pkg::t_div r_cell;

    always_comb begin
        w_rr       = {i_cell.r[18:0], i_cell.n[12]};
        w_ge       = (w_rr >= i_divisor);
        n_cell.r   = w_ge ? (w_rr - i_divisor) : w_rr;
        n_cell.q   = {i_cell.q[16:0], w_ge};
        n_cell.n   = {i_cell.n[11:0], 1'b0};
        n_cell.ovf = i_cell.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

### rtl/core/c2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Integer square root cell
// One result bit of the floor square root per cell, digit by digit.
// ----------------------------------------------------------------------------
module c2e_sqrt_cell (
    input  logic             i_clk,
    input  logic [4:0]       i_step,
    input  c2e_pkg::t_sqrt   i_cell,
    output c2e_pkg::t_sqrt   o_cell
);

    logic [37:0]    w_bit;
    logic [37:0]    w_trial;
    logic [37:0]    w_diff;
    logic           w_ge;
    c2e_pkg::t_sqrt n_cell;
    c2e_pkg::t_sqrt r_cell;

    always_comb begin
        w_bit    = 38'd1 << {i_step, 1'b0};
        w_trial  = i_cell.acc + w_bit;
        w_ge     = ({1'b0, i_cell.v} >= w_trial);
        w_diff   = {1'b0, i_cell.v} - w_trial;
        n_cell.v   = w_ge ? w_diff[36:0] : i_cell.v;
        n_cell.acc = w_ge ? ((i_cell.acc >> 1) + w_bit) : (i_cell.acc >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

### rtl/core/c2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One micro-rotation toward the x axis, accumulating the arctangent.
// ----------------------------------------------------------------------------
module c2e_cordic_cell (
    input  logic               i_clk,
    input  logic [3:0]         i_step,
    input  c2e_pkg::t_cordic   i_cell,
    output c2e_pkg::t_cordic   o_cell
);

    logic signed [21:0] w_dx;
    logic signed [21:0] w_dy;
    logic signed [20:0] w_a;
    c2e_pkg::t_cordic   n_cell;
    c2e_pkg::t_cordic   r_cell;

    always_comb begin
        w_dx = i_cell.y >>> i_step;
        w_dy = i_cell.x >>> i_step;
        w_a  = c2e_pkg::atan_q(i_step);
        if (!i_cell.y[21]) begin
            n_cell.x   = i_cell.x + w_dx;
            n_cell.y   = i_cell.y - w_dy;
            n_cell.ang = i_cell.ang + w_a;
        end else begin
            n_cell.x   = i_cell.x - w_dx;
            n_cell.y   = i_cell.y + w_dy;
            n_cell.ang = i_cell.ang - w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

### rtl/core/cubemap_to_equirect_address.sv
// ----------------------------------------------------------------------------
// Cube-map to equirectangular address generator
// Maps a cube-face pixel to the nearest equirectangular source pixel and
// returns source and destination element offsets.
// ----------------------------------------------------------------------------
// One pixel word is taken at every clock edge where start is high and busy is
// low; busy is high only in reset and the first cycle after it, so words may
// follow back to back. Each result passes 65 register stages: o_strb is high
// for exactly one cycle, and the results come in order. The depth is the cell
// chains (17 divide cells for the face coordinates, 19 square-root cells and a
// 16-cell elevation CORDIC) plus 13 single registers for input capture,
// direction, squares, angle offsets, the reciprocal scaling and the offsets.
// Results cannot be held off, so the receiver must take one word per cycle.
// Register writes are taken at any time once out of reset, but must only be
// made while no pixel is in flight.
`include "cubemap_to_equirect_address_defines.svh"

module cubemap_to_equirect_address (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  c2e_pkg::t_item     i_item,
    output logic               o_strb,
    output c2e_pkg::t_result   o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [13:0]        i_cfg_data
);

    logic                      r_busy;
    logic [c2e_pkg::LAT-1:0]   r_vld;
    logic                      w_accept;

    logic [12:0] r_res;
    logic [13:0] r_sw;
    logic [13:0] r_sh;
    logic [2:0]  r_ch;

    c2e_pkg::t_item r_s0;

    c2e_pkg::t_div  w_u   [0:c2e_pkg::UV_CELLS];
    c2e_pkg::t_div  w_v   [0:c2e_pkg::UV_CELLS];
    logic [19:0]    w_uv_div;
    logic [2:0]     r_fi  [0:c2e_pkg::FI_DLY-1];

    logic signed [18:0] w_uq;
    logic signed [18:0] w_vq;
    c2e_pkg::t_face_dir w_dir;
    logic signed [18:0] r_d0, r_d1, r_d2;
    logic [35:0]        r_sq0, r_sq2;
    logic [36:0]        r_sum;
    logic signed [18:0] r_d1_dly [0:c2e_pkg::D1_DLY-1];

    c2e_pkg::t_cordic   r_az_pre;
    c2e_pkg::t_cordic   w_az  [0:c2e_pkg::CORDIC_CELLS];
    logic signed [20:0] r_az_dly [0:c2e_pkg::AZ_DLY-1];
    c2e_pkg::t_sqrt     w_sq  [0:c2e_pkg::SQRT_CELLS];
    c2e_pkg::t_cordic   r_el_pre;
    c2e_pkg::t_cordic   w_el  [0:c2e_pkg::CORDIC_CELLS];

    logic signed [20:0] r_az_t, r_el_t;
    logic [31:0]        r_num_c, r_num_r;
    logic               r_sat_c, r_sat_r;
    logic [32:0]        w_pc, w_pr;
    logic [31:0]        w_mc, w_mr;
    logic [31:0]        r_nc_a, r_nr_a;
    logic [12:0]        r_qc_a, r_qr_a, r_qc_b, r_qr_b;
    logic               r_sat_ca, r_sat_ra, r_sat_cb, r_sat_rb;
    logic [20:0]        r_rc_b, r_rr_b;
    logic [12:0]        r_col, r_row, r_col73, r_row73, r_col74, r_row74;
    logic [26:0]        r_m;
    logic [27:0]        r_s;

    logic [24:0] r_fm1, r_frr;
    logic [11:0] r_fpc;
    logic [2:0]  r_ffi;
    logic [25:0] r_fs;
    logic [27:0] r_ff;
    logic [28:0] r_ft;
    logic [28:0] r_fo;
    logic [28:0] r_fo_dly [0:c2e_pkg::FO_DLY-1];

    c2e_pkg::t_result r_out;

    function automatic logic signed [18:0] dir_term(
        input logic signed [1:0]  c,
        input logic signed [18:0] m
    );
        logic signed [18:0] t;
        if (c == c2e_pkg::CP) begin
            t = m;
        end else if (c == c2e_pkg::CN) begin
            t = -m;
        end else begin
            t = '0;
        end
        return t;
    endfunction

    function automatic c2e_pkg::t_cordic cordic_pre(
        input logic signed [21:0] y,
        input logic signed [21:0] x
    );
        c2e_pkg::t_cordic c;
        if (x[21]) begin
            c.x   = -x;
            c.y   = -y;
            c.ang = y[21] ? -c2e_pkg::PI_Q : c2e_pkg::PI_Q;
        end else begin
            c.x   = x;
            c.y   = y;
            c.ang = '0;
        end
        return c;
    endfunction

    // control
    assign w_accept    = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[c2e_pkg::LAT-2:0], w_accept};
        end
    end

    // configuration registers, saturated on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= 13'd512;
            r_sw  <= 14'd2048;
            r_sh  <= 14'd1024;
            r_ch  <= 3'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (c2e_pkg::t_cfg_index'(i_cfg_index))
                c2e_pkg::CFG_FACE_RES: begin
                    if (i_cfg_data[12:0] == 13'd0) begin
                        r_res <= 13'd1;
                    end else if (i_cfg_data[12:0] > c2e_pkg::MAX_FACE_RES) begin
                        r_res <= c2e_pkg::MAX_FACE_RES;
                    end else begin
                        r_res <= i_cfg_data[12:0];
                    end
                end
                c2e_pkg::CFG_SRC_WIDTH: begin
                    if (i_cfg_data == 14'd0) begin
                        r_sw <= 14'd1;
                    end else if (i_cfg_data > c2e_pkg::MAX_SRC_WIDTH) begin
                        r_sw <= c2e_pkg::MAX_SRC_WIDTH;
                    end else begin
                        r_sw <= i_cfg_data;
                    end
                end
                c2e_pkg::CFG_SRC_HEIGHT: begin
                    if (i_cfg_data == 14'd0) begin
                        r_sh <= 14'd1;
                    end else if (i_cfg_data > c2e_pkg::MAX_SRC_HEIGHT) begin
                        r_sh <= c2e_pkg::MAX_SRC_HEIGHT;
                    end else begin
                        r_sh <= i_cfg_data;
                    end
                end
                c2e_pkg::CFG_CHANNELS: begin
                    if (i_cfg_data[2:0] == 3'd0) begin
                        r_ch <= 3'd1;
                    end else if (i_cfg_data[2:0] > c2e_pkg::MAX_CHANNELS) begin
                        r_ch <= c2e_pkg::MAX_CHANNELS;
                    end else begin
                        r_ch <= i_cfg_data[2:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // input capture, clamp face
    always_ff @(posedge i_clk) begin
        r_s0.pixel_row  <= i_item.pixel_row;
        r_s0.pixel_col  <= i_item.pixel_col;
        r_s0.face_index <= (i_item.face_index > c2e_pkg::FACE_MAX) ?
                           c2e_pkg::FACE_MAX : i_item.face_index;
    end

    // face coordinate dividers
    assign w_uv_div = {6'd0, r_res, 1'b0};

    always_comb begin
        w_u[0].ovf = ({1'b0, r_s0.pixel_col} >= r_res);
        w_u[0].r   = w_u[0].ovf ? 20'd0 : {7'd0, r_s0.pixel_col, 1'b0};
        w_u[0].q   = '0;
        w_u[0].n   = 13'h1000;
        w_v[0].ovf = ({1'b0, r_s0.pixel_row} >= r_res);
        w_v[0].r   = w_v[0].ovf ? 20'd0 : {7'd0, r_s0.pixel_row, 1'b0};
        w_v[0].q   = '0;
        w_v[0].n   = 13'h1000;
    end

    for (genvar g = 0; g < c2e_pkg::UV_CELLS; g++) begin : g_uv
        c2e_div_cell u_div_u (
            .i_clk     (i_clk),
            .i_divisor (w_uv_div),
            .i_cell    (w_u[g]),
            .o_cell    (w_u[g+1])
        );
        c2e_div_cell u_div_v (
            .i_clk     (i_clk),
            .i_divisor (w_uv_div),
            .i_cell    (w_v[g]),
            .o_cell    (w_v[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_fi[0] <= r_s0.face_index;
        for (int i = 1; i < c2e_pkg::FI_DLY; i++) begin
            r_fi[i] <= r_fi[i-1];
        end
    end

    // direction vector
    always_comb begin
        w_uq  = w_u[c2e_pkg::UV_CELLS].ovf ? 19'sh1FFFF :
                $signed({2'b00, w_u[c2e_pkg::UV_CELLS].q[16:0]});
        w_vq  = w_v[c2e_pkg::UV_CELLS].ovf ? 19'sh1FFFF :
                $signed({2'b00, w_v[c2e_pkg::UV_CELLS].q[16:0]});
        w_dir = c2e_pkg::face_dir(r_fi[c2e_pkg::FI_DLY-1]);
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= dir_term(w_dir.sx, c2e_pkg::ONE_Q) + dir_term(w_dir.rx, w_uq)
              + dir_term(w_dir.ux, w_vq);
        r_d1 <= dir_term(w_dir.sy, c2e_pkg::ONE_Q) + dir_term(w_dir.ry, w_uq)
              + dir_term(w_dir.uy, w_vq);
        r_d2 <= dir_term(w_dir.sz, c2e_pkg::ONE_Q) + dir_term(w_dir.rz, w_uq)
              + dir_term(w_dir.uz, w_vq);
    end

    // squares, azimuth pre-rotation
    always_ff @(posedge i_clk) begin
        r_sq0    <= 36'(r_d0 * r_d0);
        r_sq2    <= 36'(r_d2 * r_d2);
        r_az_pre <= cordic_pre(22'(r_d0), -22'(r_d2));
        r_sum    <= 37'(r_sq0) + 37'(r_sq2);
    end

    always_ff @(posedge i_clk) begin
        r_d1_dly[0] <= r_d1;
        for (int i = 1; i < c2e_pkg::D1_DLY; i++) begin
            r_d1_dly[i] <= r_d1_dly[i-1];
        end
    end

    // azimuth CORDIC
    assign w_az[0] = r_az_pre;

    for (genvar g = 0; g < c2e_pkg::CORDIC_CELLS; g++) begin : g_az
        c2e_cordic_cell u_az (
            .i_clk  (i_clk),
            .i_step (4'(g)),
            .i_cell (w_az[g]),
            .o_cell (w_az[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_az_dly[0] <= w_az[c2e_pkg::CORDIC_CELLS].ang;
        for (int i = 1; i < c2e_pkg::AZ_DLY; i++) begin
            r_az_dly[i] <= r_az_dly[i-1];
        end
    end

    // radius
    assign w_sq[0].v   = r_sum;
    assign w_sq[0].acc = '0;

    for (genvar g = 0; g < c2e_pkg::SQRT_CELLS; g++) begin : g_sq
        c2e_sqrt_cell u_sq (
            .i_clk  (i_clk),
            .i_step (5'(c2e_pkg::SQRT_CELLS - 1 - g)),
            .i_cell (w_sq[g]),
            .o_cell (w_sq[g+1])
        );
    end

    // elevation CORDIC
    always_ff @(posedge i_clk) begin
        r_el_pre <= cordic_pre(22'(r_d1_dly[c2e_pkg::D1_DLY-1]),
                               $signed({3'b000, w_sq[c2e_pkg::SQRT_CELLS].acc[18:0]}));
    end

    assign w_el[0] = r_el_pre;

    for (genvar g = 0; g < c2e_pkg::CORDIC_CELLS; g++) begin : g_el
        c2e_cordic_cell u_el (
            .i_clk  (i_clk),
            .i_step (4'(g)),
            .i_cell (w_el[g]),
            .o_cell (w_el[g+1])
        );
    end

    // angle offsets and scaling products
    always_ff @(posedge i_clk) begin
        r_az_t <= r_az_dly[c2e_pkg::AZ_DLY-1] + c2e_pkg::P_Q;
        r_el_t <= w_el[c2e_pkg::CORDIC_CELLS].ang + c2e_pkg::HP_Q;

        r_sat_c <= (r_az_t >= c2e_pkg::SPAN_Q);
        if (r_az_t[20] || r_az_t == 21'sd0 || r_az_t >= c2e_pkg::SPAN_Q) begin
            r_num_c <= '0;
        end else begin
            r_num_c <= 32'(r_az_t[18:0]) * 32'(r_sw);
        end

        r_sat_r <= (r_el_t >= c2e_pkg::P_Q);
        if (r_el_t[20] || r_el_t == 21'sd0 || r_el_t >= c2e_pkg::P_Q) begin
            r_num_r <= '0;
        end else begin
            r_num_r <= 32'(r_el_t[18:0]) * 32'(r_sh);
        end
    end

    // scaling quotients: reciprocal estimate, remainder, one correction
    always_comb begin
        w_pc = 33'(r_num_c[31:13]) * 33'(c2e_pkg::SPAN_RCP);
        w_pr = 33'(r_num_r[31:13]) * 33'(c2e_pkg::P_RCP);
        w_mc = 32'(r_qc_a) * 32'(c2e_pkg::SPAN_Q);
        w_mr = 32'(r_qr_a) * 32'(c2e_pkg::P_Q);
    end

    always_ff @(posedge i_clk) begin
        r_qc_a   <= w_pc[31:19];
        r_nc_a   <= r_num_c;
        r_sat_ca <= r_sat_c;
        r_qr_a   <= w_pr[31:19];
        r_nr_a   <= r_num_r;
        r_sat_ra <= r_sat_r;

        r_qc_b   <= r_qc_a;
        r_rc_b   <= 21'(r_nc_a - w_mc);
        r_sat_cb <= r_sat_ca;
        r_qr_b   <= r_qr_a;
        r_rr_b   <= 21'(r_nr_a - w_mr);
        r_sat_rb <= r_sat_ra;
    end

    // sample position and offset
    always_ff @(posedge i_clk) begin
        r_col   <= r_sat_cb ? 13'(r_sw - 14'd1) :
                   ((r_rc_b >= 21'(c2e_pkg::SPAN_Q)) ? r_qc_b + 13'd1 : r_qc_b);
        r_row   <= r_sat_rb ? 13'(r_sh - 14'd1) :
                   ((r_rr_b >= 21'(c2e_pkg::P_Q)) ? r_qr_b + 13'd1 : r_qr_b);
        r_m     <= 27'(r_sw) * 27'(r_row);
        r_col73 <= r_col;
        r_row73 <= r_row;
        r_s     <= 28'(r_m) + 28'(r_col73);
        r_col74 <= r_col73;
        r_row74 <= r_row73;
    end

    // destination offset
    always_ff @(posedge i_clk) begin
        r_fm1 <= 25'(r_res) * 25'(r_s0.pixel_row);
        r_frr <= 25'(r_res) * 25'(r_res);
        r_fpc <= r_s0.pixel_col;
        r_ffi <= r_s0.face_index;
        r_fs  <= 26'(r_fpc) + 26'(r_fm1);
        r_ff  <= 28'(r_ffi) * 28'(r_frr);
        r_ft  <= 29'(r_ff) + 29'(r_fs);
        r_fo  <= 29'(r_ft) * 29'(r_ch);
        r_fo_dly[0] <= r_fo;
        for (int i = 1; i < c2e_pkg::FO_DLY; i++) begin
            r_fo_dly[i] <= r_fo_dly[i-1];
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        r_out.sample_col    <= r_col74;
        r_out.sample_row    <= r_row74;
        r_out.sample_offset <= 28'(r_s) * 28'(r_ch);
        r_out.face_offset   <= r_fo_dly[c2e_pkg::FO_DLY-1];
    end

    assign o_strb   = r_vld[c2e_pkg::LAT-1];
    assign o_result = r_out;

    `C2E_ASSERT_IMP(a_strb_follows_start, i_clk, i_rst_n, o_strb, $past(w_accept, c2e_pkg::LAT))
    `C2E_ASSERT_IMP(a_quiet_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_strb)
    `C2E_ASSERT_NXT(a_ch_in_range, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, (r_ch >= 3'd1) && (r_ch <= 3'd4))

endmodule

### bench/tb_cubemap_to_equirect_address.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube-map to equirectangular addressing: testbench
// Drives cube-face pixel words through several register settings, predicts
// each source sample and both element offsets in fixed point, and checks the
// results as they stream out in order.
// ----------------------------------------------------------------------------
module tb_cubemap_to_equirect_address;

    localparam int CYCLE_LIMIT = 400000;

    class address_scoreboard;
        logic [12:0]       cfg_res;
        logic [13:0]       cfg_width;
        logic [13:0]       cfg_height;
        logic [2:0]        cfg_chan;
        c2e_pkg::t_result  pending[$];
        int                mismatches;
        int                checked;
        int          dir_tbl[54] = '{
             1,  1, -1,  -1, 0,  0,   0, -1, 0,
            -1,  1,  1,   1, 0,  0,   0, -1, 0,
            -1,  1,  1,   0, 0, -1,   1,  0, 0,
             1, -1,  1,   0, 0, -1,  -1,  0, 0,
             1,  1,  1,   0, 0, -1,   0, -1, 0,
            -1,  1, -1,   0, 0,  1,   0, -1, 0
        };
        longint      atan_tbl[16] = '{
            843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768
        };

        function new();
            cfg_res = 13'd512;
            cfg_width = 14'd2048;
            cfg_height = 14'd1024;
            cfg_chan = 3'd3;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(c2e_pkg::t_cfg_index idx, logic [13:0] data);
            case (idx)
                c2e_pkg::CFG_FACE_RES:   cfg_res = data[12:0];
                c2e_pkg::CFG_SRC_WIDTH:  cfg_width = data;
                c2e_pkg::CFG_SRC_HEIGHT: cfg_height = data;
                c2e_pkg::CFG_CHANNELS:   cfg_chan = data[2:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint q30_to_q16(longint t);
            return (t + (longint'(1) << 13)) >>> 14;
        endfunction

        function longint root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = longint'(1) << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function longint angle_of(longint yv, longint xv);
            longint cx, cy, ang, dx, dy, a;
            cx = xv;
            cy = yv;
            ang = 0;
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                ang = (yv >= 0) ? q30_to_q16(64'sd3373259426)
                                : -q30_to_q16(64'sd3373259426);
            end
            for (int k = 0; k < 16; k++) begin
                dx = cy >>> k;
                dy = cx >>> k;
                a = q30_to_q16(atan_tbl[k]);
                if (cy >= 0) begin
                    cx += dx; cy -= dy; ang += a;
                end else begin
                    cx -= dx; cy += dy; ang -= a;
                end
            end
            return ang;
        endfunction

        function longint face_coord(longint n, longint res);
            longint q;
            q = ((4 * n + 1) << 16) / (2 * res);
            return q > 131071 ? 131071 : q;
        endfunction

        function longint scale_to(longint ang, longint size, longint span);
            longint num, r;
            num = ang * size;
            if (num <= 0) return 0;
            r = num / span;
            return r > size - 1 ? size - 1 : r;
        endfunction

        function void note_pixel(c2e_pkg::t_item it);
            longint res, w, h, ch, fi, uq, vq, az, el, rad, pq, hpq, scol, srow;
            longint d[3];
            c2e_pkg::t_result r;
            res = clamp(cfg_res, 1, 4096);
            w = clamp(cfg_width, 1, 8192);
            h = clamp(cfg_height, 1, 8192);
            ch = clamp(cfg_chan, 1, 4);
            fi = it.face_index > 5 ? 5 : it.face_index;
            pq = (longint'(31415) * 65536 + 5000) / 10000;
            hpq = (longint'(31415) * 65536 + 10000) / 20000;
            uq = face_coord(it.pixel_col, res);
            vq = face_coord(it.pixel_row, res);
            for (int n = 0; n < 3; n++)
                d[n] = dir_tbl[fi*9 + n] * 65536 + dir_tbl[fi*9 + 3 + n] * uq
                     + dir_tbl[fi*9 + 6 + n] * vq;
            az = angle_of(d[0], -d[2]) + pq;
            rad = root_floor(longint'(d[0] * d[0] + d[2] * d[2]));
            el = angle_of(d[1], rad) + hpq;
            scol = scale_to(az, w, 2 * pq);
            srow = scale_to(el, h, pq);
            r.sample_col = scol[12:0];
            r.sample_row = srow[12:0];
            r.sample_offset = 28'((scol + w * srow) * ch);
            r.face_offset = 29'(fi * res * res * ch
                                + (longint'(it.pixel_col) + res * it.pixel_row) * ch);
            pending.push_back(r);
        endfunction

        function void check_result(c2e_pkg::t_result got);
            c2e_pkg::t_result want;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.sample_col !== want.sample_col) begin
                $error("sample_col expected %0d actual %0d", want.sample_col, got.sample_col);
                mismatches++;
            end
            if (got.sample_row !== want.sample_row) begin
                $error("sample_row expected %0d actual %0d", want.sample_row, got.sample_row);
                mismatches++;
            end
            if (got.sample_offset !== want.sample_offset) begin
                $error("sample_offset expected %0d actual %0d",
                       want.sample_offset, got.sample_offset);
                mismatches++;
            end
            if (got.face_offset !== want.face_offset) begin
                $error("face_offset expected %0d actual %0d",
                       want.face_offset, got.face_offset);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    c2e_pkg::t_item    i_item;
    logic              o_strb;
    c2e_pkg::t_result  o_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [13:0]       i_cfg_data;

    address_scoreboard sb;
    int cycles;
    int sent;
    int idle_pct;

    cubemap_to_equirect_address dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strb(o_strb), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && o_strb) sb.check_result(o_result);
    end

    // expects to be called just after a falling edge
    task automatic send_word(c2e_pkg::t_item it);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_pixel(it);
        sent++;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            i_item <= c2e_pkg::t_item'(27'($urandom));
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(c2e_pkg::t_cfg_index idx, logic [13:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [13:0] res, logic [13:0] w, logic [13:0] h,
                             logic [13:0] ch);
        drain();
        write_reg(c2e_pkg::CFG_FACE_RES, res);
        write_reg(c2e_pkg::CFG_SRC_WIDTH, w);
        write_reg(c2e_pkg::CFG_SRC_HEIGHT, h);
        write_reg(c2e_pkg::CFG_CHANNELS, ch);
    endtask

    task automatic random_words(int count);
        c2e_pkg::t_item it;
        int lim;
        for (int n = 0; n < count; n++) begin
            lim = int'(sb.clamp(sb.cfg_res, 1, 4096)) - 1;
            it.face_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                        : 3'($urandom_range(0, 5));
            if ($urandom_range(0, 9) == 0) begin
                it.pixel_row = 12'($urandom);
                it.pixel_col = 12'($urandom);
            end else begin
                it.pixel_row = 12'($urandom_range(0, lim));
                it.pixel_col = 12'($urandom_range(0, lim));
            end
            send_word(it);
            if (n == count / 2 && $urandom_range(0, 1)) drain();
        end
    endtask

    initial begin
        c2e_pkg::t_item it;
        logic [11:0] edges[4];
        sb = new();
        cycles = 0;
        sent = 0;
        idle_pct = 32;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners, centre and the far edge of the field on every face code
        edges = '{12'd0, 12'd255, 12'd511, 12'd4095};
        for (int f = 0; f < 8; f++) begin
            it.face_index = 3'(f);
            it.pixel_row = edges[f % 4];
            it.pixel_col = edges[(f + 1) % 4];
            send_word(it);
            it.pixel_row = edges[(f + 2) % 4];
            it.pixel_col = edges[(f + 3) % 4];
            send_word(it);
        end
        random_words(150);
        drain();

        configure(14'd1, 14'd1, 14'd1, 14'd1);
        random_words(150);
        configure(14'd4096, 14'd8192, 14'd8192, 14'd4);
        for (int f = 0; f < 6; f++) begin
            it.face_index = 3'(f);
            it.pixel_row = 12'd4095;
            it.pixel_col = (f % 2) ? 12'd0 : 12'd4095;
            send_word(it);
        end
        random_words(250);
        idle_pct = 76;
        configure(14'd0, 14'd0, 14'd0, 14'd0);
        random_words(150);
        configure(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        random_words(150);
        configure(14'd7, 14'd9000, 14'd3, 14'd2);
        random_words(200);
        idle_pct = 0;
        configure(14'($urandom_range(2, 1000)), 14'($urandom), 14'($urandom),
                  14'($urandom_range(1, 4)));
        random_words(300);
        configure(14'd512, 14'd2048, 14'd1024, 14'd3);
        random_words(300);

        drain();
        repeat (c2e_pkg::LAT + 10) @(posedge i_clk);
        $display("Sent %0d pixel words over eight register settings; %0d results checked.",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
